>>> rtl/bdq_pkg.sv
// shared constants, command and status codes, controller/datapath link types
// no dependencies
package bdq_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int NIN_W    = 7;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 8;
    localparam int LEN_W    = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_FIND       = 3'd2,
        CMD_REMOVE     = 3'd3,
        CMD_KEEP       = 3'd4,
        CMD_DROP       = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_SHORT = 2'd2
    } status_t;

    typedef struct packed {
        logic load;
        logic start;
        logic scan;
        logic exec;
    } bdq_ctl_t;

    typedef struct packed {
        logic scan_cmd;
        logic scan_done;
    } bdq_sts_t;

endpackage

>>> rtl/bdq_if.sv
// request and response channel interfaces with valid/ready handshake
// depends on bdq_pkg
interface bdq_req_if import bdq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;
    logic [NIN_W-1:0]         count;

    modport source (output valid, output cmd, output value, output count, input ready);
    modport sink (input valid, input cmd, input value, input count, output ready);
endinterface

interface bdq_res_if import bdq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [POS_W-1:0] position;
    logic [LEN_W-1:0]        length;

    modport source (output valid, output status, output position, output length, input ready);
    modport sink (input valid, input status, input position, input length, output ready);
endinterface

>>> rtl/bdq_ctrl.sv
// command sequencer: accept, execute or scan, finish and hand over the result
// depends on bdq_pkg
module bdq_ctrl import bdq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output bdq_ctl_t ctl,
    input  bdq_sts_t sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        ctl            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.scan_cmd)
                begin
                    ctl.start  = 1'b1;
                    state_next = S_SCAN;
                end
                else if (out_free)
                begin
                    ctl.exec       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SCAN:
            begin
                ctl.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    ctl.exec       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

>>> rtl/bdq_dp.sv
// datapath: circular element store, front index, length, scan and compaction
// depends on bdq_pkg; driven by bdq_ctrl through bdq_ctl_t
module bdq_dp import bdq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  bdq_ctl_t                 ctl,
    output bdq_sts_t                 sts,
    input  logic [CMD_W-1:0]         req_cmd,
    input  logic signed [DATA_W-1:0] req_value,
    input  logic [NIN_W-1:0]         req_count,
    output logic [STATUS_W-1:0]      rsp_status,
    output logic signed [POS_W-1:0]  rsp_position,
    output logic [LEN_W-1:0]         rsp_length
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = AW + 1;
    localparam int MW = (CW > NIN_W) ? CW : NIN_W;

    logic [DATA_W-1:0]   mem [CAPACITY];

    cmd_t                cmd_reg;
    logic [DATA_W-1:0]   key_reg;
    logic [NIN_W-1:0]    n_reg;

    logic [AW-1:0]       front_reg;
    logic [AW-1:0]       front_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CW-1:0]       scan_idx_reg;
    logic [CW-1:0]       scan_idx_next;
    logic [CW-1:0]       kept_reg;
    logic [CW-1:0]       kept_next;
    logic                found_reg;
    logic                found_next;
    logic [CW-1:0]       found_pos_reg;
    logic [CW-1:0]       found_pos_next;
    logic                rd_valid_reg;
    logic [CW-1:0]       data_idx_reg;
    logic [DATA_W-1:0]   rd_data_reg;

    logic [STATUS_W-1:0] status_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [LEN_W-1:0]    len_reg;

    logic                issue;
    logic                full;
    logic                eq;
    logic [AW-1:0]       rd_addr;
    logic                we;
    logic [AW-1:0]       wa;
    logic [DATA_W-1:0]   wd;
    logic [MW-1:0]       n_w;
    logic [MW-1:0]       cnt_w;
    status_t             st;
    logic [POS_W-1:0]    pos;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(k);
        if (s >= SW'(CAPACITY))
        begin
            s = s - SW'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    assign full    = (count_reg == CW'(CAPACITY));
    assign n_w     = MW'(n_reg);
    assign cnt_w   = MW'(count_reg);
    assign issue   = ctl.scan && !found_reg && (scan_idx_reg < count_reg);
    assign rd_addr = slot_of(front_reg, scan_idx_reg);
    assign eq      = (rd_data_reg == key_reg);

    assign sts.scan_cmd  = (cmd_reg == CMD_FIND) || (cmd_reg == CMD_REMOVE);
    assign sts.scan_done = !rd_valid_reg && (found_reg || (scan_idx_reg >= count_reg));

    always_comb
    begin
        front_next     = front_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        kept_next      = kept_reg;
        found_next     = found_reg;
        found_pos_next = found_pos_reg;
        we             = 1'b0;
        wa             = slot_of(front_reg, kept_reg);
        wd             = rd_data_reg;
        st             = ST_OK;
        pos            = '1;

        if (ctl.start)
        begin
            scan_idx_next = '0;
            kept_next     = '0;
            found_next    = 1'b0;
        end

        if (issue)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end

        if (rd_valid_reg)
        begin
            if ((cmd_reg == CMD_FIND) && eq && !found_reg)
            begin
                found_next     = 1'b1;
                found_pos_next = data_idx_reg + 1'b1;
            end
            if ((cmd_reg == CMD_REMOVE) && !eq)
            begin
                we        = 1'b1;
                kept_next = kept_reg + 1'b1;
            end
        end

        if (ctl.exec)
        begin
            case (cmd_reg)
                CMD_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        st = ST_FULL;
                    end
                    else
                    begin
                        front_next = (front_reg == '0) ? AW'(CAPACITY - 1)
                                                       : front_reg - 1'b1;
                        we         = 1'b1;
                        wa         = front_next;
                        wd         = key_reg;
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        st = ST_FULL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        wa         = slot_of(front_reg, count_reg);
                        wd         = key_reg;
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_FIND:
                begin
                    if (found_reg)
                    begin
                        pos = POS_W'(found_pos_reg);
                    end
                end
                CMD_REMOVE:
                begin
                    count_next = kept_reg;
                end
                CMD_KEEP:
                begin
                    if (cnt_w > n_w)
                    begin
                        count_next = CW'(n_w);
                    end
                end
                CMD_DROP:
                begin
                    if (n_w > cnt_w)
                    begin
                        st = ST_SHORT;
                    end
                    else
                    begin
                        front_next = slot_of(front_reg, CW'(n_w));
                        count_next = count_reg - CW'(n_w);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg    <= '0;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            kept_reg     <= '0;
            found_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg    <= front_next;
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            kept_reg     <= kept_next;
            found_reg    <= found_next;
            rd_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd_t'(req_cmd);
            key_reg <= req_value;
            n_reg   <= req_count;
        end
        if (ctl.exec)
        begin
            status_reg <= st;
            pos_reg    <= pos;
            len_reg    <= LEN_W'(count_next);
        end
        found_pos_reg <= found_pos_next;
        data_idx_reg  <= scan_idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rsp_status   = status_reg;
    assign rsp_position = pos_reg;
    assign rsp_length   = len_reg;

endmodule

>>> rtl/bounded_deque_with_search.sv
// bounded double-ended queue of signed 32-bit values with find and remove-all
// depends on bdq_pkg, bdq_if, bdq_ctrl, bdq_dp
//
// req channel carries one command item (cmd, value, count); rsp channel returns
// exactly one item per command (status, position, length) in command order.
// one command is in work at a time; req.ready is high while no command is held.
// push, keep and drop: the command is loaded on acceptance, then executed
// with its result registered, and the controller returns to idle for the next.
// find and remove-all: the store is walked one entry per cycle through the
// single read port of the element memory; find stops early at the first match.
// remove-all compacts in place through the write port while it walks.
// a new command is accepted while the previous result waits in the output
// register; a stalled rsp holds its item, and execution of the next command
// waits for the output register to free up.
// reset clears front index and length (queue empty); store contents are
// not cleared and no entry is read before it is written.
module bounded_deque_with_search import bdq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    bdq_req_if.sink   req,
    bdq_res_if.source rsp
);

    bdq_ctl_t ctl;
    bdq_sts_t sts;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    bdq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .req_cmd      (req.cmd),
        .req_value    (req.value),
        .req_count    (req.count),
        .rsp_status   (rsp.status),
        .rsp_position (rsp.position),
        .rsp_length   (rsp.length)
    );

endmodule

>>> rtl/bdq_checker.sv
// port-level checks for the deque block, bound to the top level
// depends on bdq_pkg and bounded_deque_with_search
module bdq_checker import bdq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    req_valid,
    input logic                    req_ready,
    input logic                    rsp_valid,
    input logic                    rsp_ready,
    input logic [STATUS_W-1:0]     rsp_status,
    input logic signed [POS_W-1:0] rsp_position,
    input logic [LEN_W-1:0]        rsp_length
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_position) && $stable(rsp_length))
        else $error("stalled rsp item changed");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second item accepted while one is in work");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_FULL) |-> rsp_length == LEN_W'(CAPACITY))
        else $error("full status with length below capacity");

    a_rst_quiet: assert property (@(posedge clk)
        !rst_n |=> !rsp_valid)
        else $error("rsp valid during reset");

endmodule

bind bounded_deque_with_search bdq_checker #(
    .CAPACITY (CAPACITY)
) u_bdq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_position (rsp.position),
    .rsp_length   (rsp.length)
);
